// ===== design/lge_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Life grid engine package
// Shared types, operation codes and the B3/S23 cell rule.
// ----------------------------------------------------------------------------
package lge_pkg;

    // Field widths fixed by the block's interface.
    localparam int FUNC_W = 2;
    localparam int COORD_W = 6;
    localparam int SIZE_W = 7;

    // Operation codes carried on the func field.
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_ADVANCE = 2'd2;

    // Grid size after reset.
    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    // Neighbor counts of the B3/S23 rule.
    localparam logic [3:0] BIRTH_COUNT = 4'd3;
    localparam logic [3:0] SURVIVE_LOW = 4'd2;
    localparam logic [3:0] SURVIVE_HIGH = 4'd3;

    // Sequencer states, one-hot.
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_ACCESS = 4'b0010,
        ST_SWEEP  = 4'b0100,
        ST_RESP   = 4'b1000
    } lge_state_t;

    // Next value of one cell from its current value and live neighbor count.
    function automatic logic lge_rule(input logic alive, input logic [3:0] count);
        logic result;
        if (alive) begin
            result = (count == SURVIVE_LOW) || (count == SURVIVE_HIGH);
        end else begin
            result = (count == BIRTH_COUNT);
        end
        return result;
    endfunction

endpackage

// ===== design/life_grid_generation_engine.sv =====
`timescale 1ns / 1ps
// A read or write in range passes through the access state to the result state;
// an out-of-range access or an unused code goes straight to the result state.
// An advance sweeps the row RAM one row per cycle and then gives its result;
// one item is in flight.
// Reset is synchronous and active low; it clears the per-row valid bits, so the
// whole grid reads as dead at once, and sets the grid size to 64.
// ----------------------------------------------------------------------------
// Life grid generation engine
// Square bit grid with cell read, cell write and B3/S23 generation advance.
// The row RAM is swept through a three-row window and one row evaluator.
// ----------------------------------------------------------------------------
module life_grid_generation_engine #(
    parameter int GRID_MAX = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Configuration port
    input  logic                         cfg_we,
    input  logic [lge_pkg::SIZE_W-1:0]   cfg_wdata,
    // Input channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [lge_pkg::FUNC_W-1:0]   s_func,
    input  logic [lge_pkg::COORD_W-1:0]  s_row,
    input  logic [lge_pkg::COORD_W-1:0]  s_col,
    input  logic                         s_cell_in,
    // Result channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_cell_out,
    output logic                         m_out_of_range
);

    localparam int IDX_W = $clog2(GRID_MAX);
    localparam int NW = ($clog2(GRID_MAX + 2) > lge_pkg::SIZE_W) ?
                        $clog2(GRID_MAX + 2) : lge_pkg::SIZE_W;

    lge_pkg::lge_state_t state_reg, state_next;

    logic [lge_pkg::SIZE_W-1:0]  grid_size_reg;
    logic [NW-1:0]               cnt_reg, cnt_next;
    logic [GRID_MAX-1:0]         prev_reg, prev_next;
    logic [GRID_MAX-1:0]         cur_reg, cur_next;
    logic [GRID_MAX-1:0]         row_valid_reg, row_valid_next;
    logic                        rd_ok_reg, rd_ok_next;
    logic [lge_pkg::FUNC_W-1:0]  req_func_reg, req_func_next;
    logic [IDX_W-1:0]            req_col_reg, req_col_next;
    logic [IDX_W-1:0]            req_row_reg, req_row_next;
    logic                        req_cell_reg, req_cell_next;
    logic                        out_cell_reg, out_cell_next;
    logic                        out_oor_reg, out_oor_next;

    logic [NW-1:0]               size_ext;
    logic [NW-1:0]               n_act;
    logic [GRID_MAX-1:0]         col_mask;
    logic [GRID_MAX-1:0]         row_data;
    logic [GRID_MAX-1:0]         new_row;
    logic                        in_xfer;
    logic                        is_rw;
    logic                        req_oor;

    logic                        ram_we;
    logic [IDX_W-1:0]            ram_waddr;
    logic [GRID_MAX-1:0]         ram_wdata;
    logic [IDX_W-1:0]            ram_raddr;
    logic [GRID_MAX-1:0]         ram_rdata;

    // Row store: one word per grid row.
    lge_ram #(
        .WIDTH (GRID_MAX),
        .DEPTH (GRID_MAX)
    ) u_rows (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Active size is the register clamped to the storage size.
    assign size_ext = NW'(grid_size_reg);
    assign n_act = (size_ext > NW'(GRID_MAX)) ? NW'(GRID_MAX) : size_ext;

    // Columns inside the active square.
    always_comb begin
        for (int j = 0; j < GRID_MAX; j++) begin
            col_mask[j] = (NW'(j) < n_act);
        end
    end

    // A row never written, or beyond the active square, reads as dead.
    assign row_data = rd_ok_reg ? ram_rdata : '0;

    // Row evaluator: the window holds rows k-1 and k, the RAM output row k+1.
    always_comb begin
        logic [GRID_MAX+1:0] pe;
        logic [GRID_MAX+1:0] ce;
        logic [GRID_MAX+1:0] ne;
        logic [3:0]          nb;
        pe = {1'b0, prev_reg & col_mask, 1'b0};
        ce = {1'b0, cur_reg & col_mask, 1'b0};
        ne = {1'b0, row_data & col_mask, 1'b0};
        nb = '0;
        for (int j = 0; j < GRID_MAX; j++) begin
            nb = 4'(pe[j]) + 4'(pe[j+1]) + 4'(pe[j+2]) + 4'(ce[j]) + 4'(ce[j+2])
               + 4'(ne[j]) + 4'(ne[j+1]) + 4'(ne[j+2]);
            // Columns outside the active square keep their old value.
            new_row[j] = col_mask[j] ? lge_pkg::lge_rule(cur_reg[j], nb) : cur_reg[j];
        end
    end

    assign s_ready = (state_reg == lge_pkg::ST_IDLE);
    assign in_xfer = s_valid && s_ready;
    assign is_rw = (s_func == lge_pkg::FUNC_WRITE) || (s_func == lge_pkg::FUNC_READ);
    assign req_oor = is_rw && ((NW'(s_row) >= n_act) || (NW'(s_col) >= n_act));

    // Sequencer and datapath next-state logic.
    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        prev_next = prev_reg;
        cur_next = cur_reg;
        row_valid_next = row_valid_reg;
        rd_ok_next = 1'b0;
        req_func_next = req_func_reg;
        req_col_next = req_col_reg;
        req_row_next = req_row_reg;
        req_cell_next = req_cell_reg;
        out_cell_next = out_cell_reg;
        out_oor_next = out_oor_reg;
        ram_we = 1'b0;
        ram_waddr = IDX_W'(cnt_reg - NW'(2));
        ram_wdata = new_row;
        ram_raddr = cnt_reg[IDX_W-1:0];

        case (state_reg)
            lge_pkg::ST_IDLE: begin
                ram_raddr = IDX_W'(s_row);
                if (in_xfer) begin
                    req_func_next = s_func;
                    req_row_next = IDX_W'(s_row);
                    req_col_next = IDX_W'(s_col);
                    req_cell_next = s_cell_in;
                    out_cell_next = 1'b0;
                    out_oor_next = req_oor;
                    if (is_rw && !req_oor) begin
                        // Row is read now; the access completes next cycle.
                        rd_ok_next = row_valid_reg[IDX_W'(s_row)];
                        state_next = lge_pkg::ST_ACCESS;
                    end else if (s_func == lge_pkg::FUNC_ADVANCE) begin
                        cnt_next = '0;
                        prev_next = '0;
                        cur_next = '0;
                        state_next = lge_pkg::ST_SWEEP;
                    end else begin
                        state_next = lge_pkg::ST_RESP;
                    end
                end
            end

            lge_pkg::ST_ACCESS: begin
                // Read picks one bit; write merges one bit back into the row.
                ram_waddr = req_row_reg;
                ram_wdata = row_data;
                ram_wdata[req_col_reg] = req_cell_reg;
                if (req_func_reg == lge_pkg::FUNC_WRITE) begin
                    ram_we = 1'b1;
                    row_valid_next[req_row_reg] = 1'b1;
                end else begin
                    out_cell_next = row_data[req_col_reg];
                end
                state_next = lge_pkg::ST_RESP;
            end

            lge_pkg::ST_SWEEP: begin
                // Read row cnt, evaluate row cnt-2 and write it back.
                rd_ok_next = (cnt_reg < n_act) && row_valid_reg[cnt_reg[IDX_W-1:0]];
                if (cnt_reg >= NW'(1)) begin
                    prev_next = cur_reg;
                    cur_next = row_data;
                end
                if (cnt_reg >= NW'(2)) begin
                    ram_we = 1'b1;
                    row_valid_next[ram_waddr] = 1'b1;
                end
                if (cnt_reg == n_act + NW'(1)) begin
                    state_next = lge_pkg::ST_RESP;
                end else begin
                    cnt_next = cnt_reg + NW'(1);
                end
            end

            lge_pkg::ST_RESP: begin
                if (m_ready) begin
                    state_next = lge_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = lge_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers with synchronous reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lge_pkg::ST_IDLE;
            grid_size_reg <= lge_pkg::SIZE_RESET;
            row_valid_reg <= '0;
            rd_ok_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            row_valid_reg <= row_valid_next;
            rd_ok_reg <= rd_ok_next;
            if (cfg_we) begin
                grid_size_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        prev_reg <= prev_next;
        cur_reg <= cur_next;
        req_func_reg <= req_func_next;
        req_row_reg <= req_row_next;
        req_col_reg <= req_col_next;
        req_cell_reg <= req_cell_next;
        out_cell_reg <= out_cell_next;
        out_oor_reg <= out_oor_next;
    end

    assign m_valid = (state_reg == lge_pkg::ST_RESP);
    assign m_cell_out = out_cell_reg;
    assign m_out_of_range = out_oor_reg;

    // The RAM is written only by a cell write or by the sweep.
    a_ram_write_src: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == lge_pkg::ST_ACCESS) || (state_reg == lge_pkg::ST_SWEEP))
        else $error("row RAM written outside access or sweep");

    // The sweep counter never exceeds the active size plus one.
    a_sweep_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lge_pkg::ST_SWEEP) |-> (cnt_reg <= n_act + NW'(1)))
        else $error("sweep counter out of bounds");

    // An advance transfer starts a sweep.
    a_advance_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && (s_func == lge_pkg::FUNC_ADVANCE)) |=> (state_reg == lge_pkg::ST_SWEEP))
        else $error("advance did not start a sweep");

    // An out-of-range result never carries a cell value.
    a_oor_no_cell: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_out_of_range) |-> !m_cell_out)
        else $error("out-of-range result carries a cell value");

    // No new item is taken while a result is pending.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input ready while a result is pending");

endmodule

// ===== design/lge_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lge_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== tb/life_grid_generation_engine_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Life grid generation engine checker
// Watches the configuration port and both channels. It keeps its own copy
// of the cell grid and the grid size, predicts the result of each accepted
// input transfer, and compares every result transfer with the oldest
// outstanding prediction.
// ----------------------------------------------------------------------------
module life_grid_generation_engine_checker #(
    parameter int GRID_MAX = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [lge_pkg::SIZE_W-1:0]   cfg_wdata,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic [lge_pkg::FUNC_W-1:0]   s_func,
    input  logic [lge_pkg::COORD_W-1:0]  s_row,
    input  logic [lge_pkg::COORD_W-1:0]  s_col,
    input  logic                         s_cell_in,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic                         m_cell_out,
    input  logic                         m_out_of_range,
    output int                           fail_count,
    output int                           pending_results
);

    typedef struct packed {
        logic cell_out;
        logic out_of_range;
    } cell_result_t;

    // Mirror of the cell store and the size register.
    logic [GRID_MAX-1:0]        life_grid [GRID_MAX];
    logic [lge_pkg::SIZE_W-1:0] grid_size_reg;
    cell_result_t               cell_result_q [$];

    // The programmed size is clamped to the storage that exists.
    function automatic int active_size();
        return (grid_size_reg > GRID_MAX) ? GRID_MAX : int'(grid_size_reg);
    endfunction

    // One B3/S23 generation over the active square; cells outside it count as
    // dead and keep their values.
    function automatic void step_generation(input int n);
        logic [GRID_MAX-1:0] next_rows [GRID_MAX];
        int live;
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c < n; c++) begin
                live = 0;
                for (int dr = -1; dr <= 1; dr++) begin
                    for (int dc = -1; dc <= 1; dc++) begin
                        if ((dr != 0 || dc != 0) && (r + dr >= 0) && (r + dr < n) &&
                            (c + dc >= 0) && (c + dc < n)) begin
                            live += int'(life_grid[r + dr][c + dc]);
                        end
                    end
                end
                if (life_grid[r][c]) begin
                    next_rows[r][c] = (live == lge_pkg::SURVIVE_LOW) ||
                                      (live == lge_pkg::SURVIVE_HIGH);
                end else begin
                    next_rows[r][c] = (live == lge_pkg::BIRTH_COUNT);
                end
            end
        end
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c < n; c++) begin
                life_grid[r][c] = next_rows[r][c];
            end
        end
    endfunction

    // Applies one input item to the mirror and returns the result it causes.
    function automatic cell_result_t apply_item(input logic [lge_pkg::FUNC_W-1:0] func,
                                                input logic [lge_pkg::COORD_W-1:0] row,
                                                input logic [lge_pkg::COORD_W-1:0] col,
                                                input logic cell_in);
        cell_result_t res;
        int n;
        res = '0;
        n = active_size();
        if (func == lge_pkg::FUNC_WRITE || func == lge_pkg::FUNC_READ) begin
            if (row >= n || col >= n) begin
                res.out_of_range = 1'b1;
            end else if (func == lge_pkg::FUNC_WRITE) begin
                life_grid[row][col] = cell_in;
            end else begin
                res.cell_out = life_grid[row][col];
            end
        end else if (func == lge_pkg::FUNC_ADVANCE) begin
            step_generation(n);
        end
        return res;
    endfunction

    always @(posedge aclk) begin : monitor
        cell_result_t want;
        if (!aresetn) begin
            for (int r = 0; r < GRID_MAX; r++) begin
                life_grid[r] = '0;
            end
            grid_size_reg = lge_pkg::SIZE_RESET;
            cell_result_q.delete();
            fail_count = 0;
        end else begin
            // Result transfer: compare with the oldest prediction.
            if (m_valid && m_ready) begin
                if (cell_result_q.size() == 0) begin
                    $display("%0t: result transfer with nothing outstanding", $time);
                    fail_count++;
                end else begin
                    want = cell_result_q.pop_front();
                    if (m_cell_out !== want.cell_out) begin
                        $display("%0t: cell_out mismatch, expected %0b, actual %0b",
                                 $time, want.cell_out, m_cell_out);
                        fail_count++;
                    end
                    if (m_out_of_range !== want.out_of_range) begin
                        $display("%0t: out_of_range mismatch, expected %0b, actual %0b",
                                 $time, want.out_of_range, m_out_of_range);
                        fail_count++;
                    end
                end
            end
            // Input transfer: predict its result with the current size.
            if (s_valid && s_ready) begin
                cell_result_q = {cell_result_q, apply_item(s_func, s_row, s_col, s_cell_in)};
            end
            if (cfg_we) begin
                grid_size_reg = cfg_wdata;
            end
        end
        pending_results = cell_result_q.size();
    end

endmodule

// ===== tb/life_grid_generation_engine_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Life grid generation engine testbench
// Drives cell writes, cell reads and generation steps with random gaps on
// both channels, reprograms the grid size between phases, and gives the
// verdict from the failure count of the checker.
// ----------------------------------------------------------------------------
module life_grid_generation_engine_tb;

    typedef logic [lge_pkg::FUNC_W-1:0]  func_t;
    typedef logic [lge_pkg::COORD_W-1:0] coord_t;
    typedef logic [lge_pkg::SIZE_W-1:0]  size_t;

    localparam int GRID_MAX = 64;
    localparam int CLK_PERIOD = 12;
    localparam int RESET_CYCLES = 11;
    localparam int ITEM_TARGET = 1950;
    localparam int PHASE_ITEMS = 150;
    localparam int MAX_GAP = 6;
    localparam int WINDOW_MAX = 8;
    localparam int CFG_PAUSE = 4;
    localparam int TAIL_CYCLES = GRID_MAX + 8;
    localparam int IDLE_LIMIT = 2000;
    localparam func_t FUNC_UNUSED = 2'd3;

    logic    aclk = 1'b0;
    logic    aresetn = 1'b0;
    logic    cfg_we = 1'b0;
    size_t   cfg_wdata = '0;
    logic    s_valid = 1'b0;
    logic    s_ready;
    func_t   s_func = lge_pkg::FUNC_WRITE;
    coord_t  s_row = '0;
    coord_t  s_col = '0;
    logic    s_cell_in = 1'b0;
    logic    m_valid;
    logic    m_ready = 1'b0;
    logic    m_cell_out;
    logic    m_out_of_range;

    logic quiet_phase = 1'b0;
    int   fail_count;
    int   pending_results;
    int   idle_cycles = 0;
    int   items_sent = 0;

    life_grid_generation_engine #(
        .GRID_MAX(GRID_MAX)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_func(s_func),
        .s_row(s_row),
        .s_col(s_col),
        .s_cell_in(s_cell_in),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_cell_out(m_cell_out),
        .m_out_of_range(m_out_of_range)
    );

    life_grid_generation_engine_checker #(
        .GRID_MAX(GRID_MAX)
    ) grid_checker (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_func(s_func),
        .s_row(s_row),
        .s_col(s_col),
        .s_cell_in(s_cell_in),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_cell_out(m_cell_out),
        .m_out_of_range(m_out_of_range),
        .fail_count(fail_count),
        .pending_results(pending_results)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // Gap before a transfer; some phases run with no gaps at all.
    function automatic int draw_gap();
        if (quiet_phase) begin
            return 0;
        end
        return int'($urandom_range(MAX_GAP, 0));
    endfunction

    // Grid size for each phase: fixed corners first, then random sizes.
    function automatic size_t plan_size(input int phase);
        case (phase)
            0:  return 7'd64;
            1:  return 7'd1;
            2:  return 7'd0;
            3:  return 7'd2;
            4:  return 7'd127;
            5:  return 7'd3;
            6:  return 7'd8;
            7:  return 7'd65;
            8:  return 7'd16;
            9:  return 7'd5;
            10: return 7'd33;
            11: return 7'd64;
            default: begin
                if ($urandom_range(9, 0) == 0) begin
                    return size_t'($urandom_range(127, 0));
                end
                return size_t'($urandom_range(64, 1));
            end
        endcase
    endfunction

    // One input transfer, after a random gap; valid stays high between
    // back-to-back items.
    task automatic send_item(input func_t func,
                             input coord_t row,
                             input coord_t col,
                             input logic cell_val);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_func    <= func;
        s_row     <= row;
        s_col     <= col;
        s_cell_in <= cell_val;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // Waits until every predicted result has arrived, then a short pause.
    task automatic wait_drained(input int pause);
        @(negedge aclk);
        while (pending_results != 0) @(negedge aclk);
        repeat (pause) @(posedge aclk);
    endtask

    // Size register write, only once the block has gone idle.
    task automatic set_grid_size(input size_t size);
        s_valid <= 1'b0;
        wait_drained(CFG_PAUSE);
        cfg_we    <= 1'b1;
        cfg_wdata <= size;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Result side: random stalls counted from the moment a result is offered.
    initial begin : result_sink
        int stall;
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                m_ready <= 1'b0;
                do @(posedge aclk); while (!m_valid);
                repeat (stall - 1) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int phase;
        int phase_end;
        int active;
        int win;
        int org_r;
        int org_c;
        size_t size_now;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: cleared store, grid corners and the unused code at the
        // reset size, then a blinker across one generation.
        send_item(lge_pkg::FUNC_READ, 6'd0, 6'd0, 1'b0);
        send_item(lge_pkg::FUNC_WRITE, 6'd0, 6'd0, 1'b1);
        send_item(lge_pkg::FUNC_WRITE, 6'd0, 6'd63, 1'b1);
        send_item(lge_pkg::FUNC_WRITE, 6'd63, 6'd0, 1'b1);
        send_item(lge_pkg::FUNC_WRITE, 6'd63, 6'd63, 1'b1);
        send_item(lge_pkg::FUNC_READ, 6'd63, 6'd63, 1'b0);
        send_item(FUNC_UNUSED, 6'd63, 6'd63, 1'b1);
        send_item(lge_pkg::FUNC_WRITE, 6'd10, 6'd9, 1'b1);
        send_item(lge_pkg::FUNC_WRITE, 6'd10, 6'd10, 1'b1);
        send_item(lge_pkg::FUNC_WRITE, 6'd10, 6'd11, 1'b1);
        send_item(lge_pkg::FUNC_ADVANCE, 6'd0, 6'd0, 1'b0);
        send_item(lge_pkg::FUNC_READ, 6'd9, 6'd10, 1'b0);
        send_item(lge_pkg::FUNC_READ, 6'd11, 6'd10, 1'b0);
        send_item(lge_pkg::FUNC_READ, 6'd10, 6'd9, 1'b0);
        send_item(lge_pkg::FUNC_READ, 6'd0, 6'd0, 1'b0);

        // Size zero: every access is out of range and a step does nothing.
        set_grid_size(7'd0);
        send_item(lge_pkg::FUNC_WRITE, 6'd0, 6'd0, 1'b1);
        send_item(lge_pkg::FUNC_READ, 6'd0, 6'd0, 1'b0);
        send_item(lge_pkg::FUNC_ADVANCE, 6'd63, 6'd63, 1'b1);

        // A size above the storage clamps to the full grid.
        set_grid_size(7'd127);
        send_item(lge_pkg::FUNC_READ, 6'd10, 6'd10, 1'b0);
        send_item(lge_pkg::FUNC_WRITE, 6'd63, 6'd63, 1'b1);

        // Small grid: blinker at the edges, out-of-range on each axis, and
        // cells outside the square left untouched by the step.
        set_grid_size(7'd3);
        send_item(lge_pkg::FUNC_WRITE, 6'd0, 6'd1, 1'b1);
        send_item(lge_pkg::FUNC_WRITE, 6'd1, 6'd1, 1'b1);
        send_item(lge_pkg::FUNC_WRITE, 6'd2, 6'd1, 1'b1);
        send_item(lge_pkg::FUNC_ADVANCE, 6'd0, 6'd0, 1'b0);
        send_item(lge_pkg::FUNC_READ, 6'd1, 6'd0, 1'b0);
        send_item(lge_pkg::FUNC_READ, 6'd3, 6'd0, 1'b0);
        send_item(lge_pkg::FUNC_READ, 6'd0, 6'd3, 1'b0);
        set_grid_size(7'd64);
        send_item(lge_pkg::FUNC_READ, 6'd63, 6'd63, 1'b0);
        send_item(lge_pkg::FUNC_READ, 6'd10, 6'd10, 1'b0);

        // Random phases: seed a pattern in a window, step it, read it back,
        // with stray accesses and unused codes mixed in.
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            size_now = plan_size(phase);
            set_grid_size(size_now);
            quiet_phase <= (phase % 5 == 4);
            active = (size_now > GRID_MAX) ? GRID_MAX : int'(size_now);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end && items_sent < ITEM_TARGET) begin
                win = (active < WINDOW_MAX) ? active : int'($urandom_range(WINDOW_MAX, 3));
                org_r = (active > win) ? int'($urandom_range(active - win, 0)) : 0;
                org_c = (active > win) ? int'($urandom_range(active - win, 0)) : 0;
                repeat ($urandom_range(12, 3)) begin
                    if (win == 0 || $urandom_range(9, 0) == 0) begin
                        send_item(func_t'($urandom_range(3, 0)),
                                  coord_t'($urandom_range(63, 0)),
                                  coord_t'($urandom_range(63, 0)),
                                  1'($urandom_range(1, 0)));
                    end else begin
                        send_item(lge_pkg::FUNC_WRITE,
                                  coord_t'(org_r + int'($urandom_range(win - 1, 0))),
                                  coord_t'(org_c + int'($urandom_range(win - 1, 0))),
                                  $urandom_range(9, 0) < 6);
                    end
                end
                repeat ($urandom_range(3, 1)) begin
                    send_item(lge_pkg::FUNC_ADVANCE, coord_t'($urandom_range(63, 0)),
                              coord_t'($urandom_range(63, 0)), 1'($urandom_range(1, 0)));
                end
                repeat ($urandom_range(6, 2)) begin
                    if (win == 0 || $urandom_range(7, 0) == 0) begin
                        send_item(lge_pkg::FUNC_READ, coord_t'($urandom_range(63, 0)),
                                  coord_t'($urandom_range(63, 0)),
                                  1'($urandom_range(1, 0)));
                    end else begin
                        send_item(lge_pkg::FUNC_READ,
                                  coord_t'(org_r + int'($urandom_range(win - 1, 0))),
                                  coord_t'(org_c + int'($urandom_range(win - 1, 0))),
                                  1'($urandom_range(1, 0)));
                    end
                end
            end
            phase++;
        end

        // Drain the last results and leave room for any stray transfer.
        s_valid <= 1'b0;
        wait_drained(TAIL_CYCLES);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/lge_pkg.sv
design/lge_ram.sv
design/life_grid_generation_engine.sv
tb/life_grid_generation_engine_checker.sv
tb/life_grid_generation_engine_tb.sv
